[src/sfla_pkg.sv]
package sfla_pkg;

  localparam int MODE_W    = 2;
  localparam int SLOT_W    = 16;
  localparam int OFFSET_W  = 30;
  localparam int STATUS_W  = 2;
  localparam int FREE_W    = 11;
  localparam int BSIZE_W   = 21;
  localparam int CAP_W     = 11;
  localparam int PROD_W    = SLOT_W + BSIZE_W;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(4096);
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(1024);

  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCATE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

  localparam logic REG_SLOT_BYTES = 1'b0;
  localparam logic REG_CAPACITY   = 1'b1;

  typedef struct packed {
    logic restart;
    logic clr;
    logic take;
    logic decide;
    logic finish;
  } sfla_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } sfla_sts_t;

endpackage

[src/sfla_if.sv]
interface sfla_in_if import sfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, mode, slot, input ready);
  modport sink (input valid, mode, slot, output ready);
endinterface

interface sfla_out_if import sfla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_out;
  logic [OFFSET_W-1:0] byte_offset;
  logic [STATUS_W-1:0] status;
  logic [FREE_W-1:0]   free_left;

  modport source (output valid, slot_out, byte_offset, status, free_left, input ready);
  modport sink (input valid, slot_out, byte_offset, status, free_left, output ready);
endinterface

[src/slot_free_list_allocator_top.sv]
// Buffer slot allocator with a LIFO free list. Each transaction on the input
// channel acquires, releases or locates a slot and yields one result
// transaction. An item passes through three steps from acceptance to a loaded
// result (accept, then lookup through the registered read of the free-stack
// and busy-bit RAMs together with the offset multiply, then saturation into
// the output register), and no item is accepted until the one before has
// finished its last step; a result waiting on the output holds back the next
// item's last step only. After reset, and after every write of capacity, a
// clearing pass refills the free stack and clears the busy bits one slot per
// cycle for min(capacity, MAX_SLOTS) slots, and no item is accepted during it.
// Registers: bytes per slot at byte 0x0, capacity at byte 0x4.
module slot_free_list_allocator_top import sfla_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  sfla_in_if.sink            in,
  sfla_out_if.source         out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [BSIZE_W-1:0] slot_bytes;
  logic [CAP_W-1:0]   capacity;
  logic               reg_wr;
  logic               cap_wr;
  sfla_cmd_t          cmd;
  sfla_sts_t          sts;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign cap_wr = reg_wr && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bytes <= BSIZE_RESET;
      capacity   <= CAP_RESET;
    end else if (reg_wr) begin
      if (paddr[2] == REG_SLOT_BYTES) begin
        slot_bytes <= pwdata[BSIZE_W-1:0];
      end else begin
        capacity <= pwdata[CAP_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : PDATA_W'(slot_bytes);

  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cap_wr   (cap_wr),
    .in_valid (in.valid),
    .in_ready (in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfla_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .slot_bytes  (slot_bytes),
    .capacity    (capacity),
    .in_mode     (in.mode),
    .in_slot     (in.slot),
    .out_ready   (out.ready),
    .out_valid   (out.valid),
    .slot_out    (out.slot_out),
    .byte_offset (out.byte_offset),
    .status      (out.status),
    .free_left   (out.free_left)
  );

  // no input transaction during the clearing pass
  assert property (@(posedge clk) disable iff (rst) cmd.clr |-> !in.ready)
    else $error("input accepted during clearing pass");

  // one item in flight at a time
  assert property (@(posedge clk) disable iff (rst) (in.valid && in.ready) |=> !in.ready)
    else $error("input accepted while an item is in flight");

  assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.status != ST_OK) |-> (out.byte_offset == '0))
    else $error("nonzero offset on a failed transaction");

  assert property (@(posedge clk) disable iff (rst)
    (out.valid && !cap_wr) |-> (out.free_left <= capacity))
    else $error("free count above capacity");

endmodule

[src/sfla_ram.sv]
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sfla_ctrl.sv]
module sfla_ctrl import sfla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cap_wr,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfla_sts_t sts,
  output sfla_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !cap_wr;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.restart = cap_wr;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.decide = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (cap_wr) begin
      state_next = S_CLEAR;
    end
  end

endmodule

[src/sfla_dp.sv]
module sfla_dp import sfla_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  sfla_cmd_t           cmd,
  output sfla_sts_t           sts,
  input  logic [BSIZE_W-1:0]  slot_bytes,
  input  logic [CAP_W-1:0]    capacity,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [OFFSET_W-1:0] byte_offset,
  output logic [STATUS_W-1:0] status,
  output logic [FREE_W-1:0]   free_left
);

  localparam int AW   = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW = CW > CAP_W ? CW : CAP_W;
  localparam int RW   = SLOT_W + 1;

  logic [CW-1:0]       count;
  logic [CW-1:0]       clr_idx;
  logic [MODE_W-1:0]   op_mode;
  logic [SLOT_W-1:0]   op_slot;
  logic [PROD_W-1:0]   prod;
  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;

  logic [CMPW-1:0]     cap_ext;
  logic [CW-1:0]       eff_cap;
  logic [CW-1:0]       count_dec;
  logic [CW-1:0]       fill_val;
  logic                clr_wr;
  logic                in_range;

  logic                stk_we;
  logic [AW-1:0]       stk_waddr;
  logic [AW-1:0]       stk_wdata;
  logic [AW-1:0]       stk_rdata;
  logic                busy_we;
  logic [AW-1:0]       busy_waddr;
  logic                busy_wdata;
  logic                busy_rdata;

  logic [STATUS_W-1:0] dec_status;
  logic [SLOT_W-1:0]   dec_slot;
  logic [CW-1:0]       count_next;
  logic [CW+FREE_W-1:0] count_ext;

  assign cap_ext   = CMPW'(capacity);
  assign eff_cap   = (cap_ext > CMPW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cap_ext);
  assign count_dec = count - CW'(1);
  assign fill_val  = eff_cap - clr_idx - CW'(1);
  assign in_range  = RW'(op_slot) < RW'(eff_cap);

  assign sts.clr_done = (clr_idx >= eff_cap);
  assign sts.out_free = !out_valid || out_ready;
  assign clr_wr       = cmd.clr && !cmd.restart && !sts.clr_done;

  // decision on the looked-up stack top and busy bit
  always_comb begin
    dec_status = ST_OK;
    dec_slot   = op_slot;
    count_next = count;
    stk_we     = 1'b0;
    stk_waddr  = count[AW-1:0];
    stk_wdata  = op_slot[AW-1:0];
    busy_we    = 1'b0;
    busy_waddr = op_slot[AW-1:0];
    busy_wdata = 1'b0;
    case (op_mode)
      MODE_ACQUIRE: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
          dec_slot   = '0;
        end else begin
          dec_slot   = SLOT_W'(stk_rdata);
          count_next = count_dec;
          busy_we    = cmd.decide;
          busy_waddr = stk_rdata;
          busy_wdata = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (!in_range) begin
          dec_status = ST_RANGE;
        end else if (!busy_rdata || count >= CW'(MAX_SLOTS)) begin
          dec_status = ST_DOUBLE;
        end else begin
          count_next = count + CW'(1);
          stk_we     = cmd.decide;
          busy_we    = cmd.decide;
        end
      end
      MODE_LOCATE: begin
        if (!in_range) begin
          dec_status = ST_RANGE;
        end
      end
      default: begin
        dec_status = ST_RANGE;
      end
    endcase
    if (clr_wr) begin
      stk_we     = 1'b1;
      stk_waddr  = clr_idx[AW-1:0];
      stk_wdata  = fill_val[AW-1:0];
      busy_we    = 1'b1;
      busy_waddr = clr_idx[AW-1:0];
      busy_wdata = 1'b0;
    end
  end

  sfla_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (count_dec[AW-1:0]),
    .rdata (stk_rdata)
  );

  sfla_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (in_slot[AW-1:0]),
    .rdata (busy_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.restart) begin
      clr_idx <= '0;
    end else if (clr_wr) begin
      clr_idx <= clr_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clr) begin
      count <= eff_cap;
    end else if (cmd.decide) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_mode <= in_mode;
      op_slot <= in_slot;
    end
    if (cmd.decide) begin
      res_slot   <= dec_slot;
      res_status <= dec_status;
      prod       <= {{BSIZE_W{1'b0}}, dec_slot} * {{SLOT_W{1'b0}}, slot_bytes};
    end
  end

  assign count_ext = (CW + FREE_W)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      slot_out  <= res_slot;
      status    <= res_status;
      free_left <= count_ext[FREE_W-1:0];
      if (res_status != ST_OK) begin
        byte_offset <= '0;
      end else if (prod[PROD_W-1:OFFSET_W] != '0) begin
        byte_offset <= '1;
      end else begin
        byte_offset <= prod[OFFSET_W-1:0];
      end
    end
  end

endmodule
